@@ rtl/core/b2da_pkg.sv @@
`timescale 1ns / 1ps

package b2da_pkg;

   // front: value capture and binary to bcd conversion
   typedef enum logic [1:0] {
      FE_IDLE,
      FE_CONVERT,
      FE_PUSH
   } front_state_type;

   // back: character sequencing
   typedef enum logic [2:0] {
      BE_IDLE,
      BE_SPACE,
      BE_OPEN,
      BE_DIGITS,
      BE_PERCENT,
      BE_CLOSE
   } back_state_type;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_OPEN    = 8'h3C;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_CLOSE   = 8'h3E;

   localparam logic [3:0] BCD_ADJUST_MIN = 4'd5;
   localparam logic [3:0] BCD_ADJUST_ADD = 4'd3;

   // register word index, taken from the word address bit
   localparam logic CSR_LABEL_MODE = 1'b0;

endpackage

@@ rtl/core/b2da_front.sv @@
`timescale 1ns / 1ps

module b2da_front #(
   parameter int MAX_DIGITS = 10,
   parameter int VALUE_BITS = 32,
   parameter int CNT_BITS   = 4,
   parameter int ENTRY_BITS = 45
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  label_mode,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  push_valid,
   input  logic                  push_ready,
   output logic [ENTRY_BITS-1:0] push_data
);

   localparam int PAD_BITS  = VALUE_BITS + (VALUE_BITS % 2);
   localparam int STEPS     = PAD_BITS / 2;
   localparam int STEP_BITS = $clog2(STEPS);
   localparam int BCD_BITS  = MAX_DIGITS * 4;

   b2da_pkg::front_state_type state_ff, state_in;

   logic [PAD_BITS-1:0]  shift_ff, shift_in;
   logic [BCD_BITS-1:0]  bcd_ff, bcd_in;
   logic                 ovf_ff, ovf_in;
   logic                 framed_ff, framed_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   logic [VALUE_BITS-1:0] scaled;
   logic [BCD_BITS-1:0]   adj_a, mid, adj_b, bcd_step;
   logic                  carry_a, carry_b;
   logic [CNT_BITS-1:0]   top_digit, count;
   logic                  accept;

   // times five wraps at the value width
   assign scaled = label_mode ? ((req_value << 2) + req_value) : req_value;
   assign accept = req_valid & req_ready;

   // two double-dabble steps per cycle; a carry out of the top digit means dropped digits
   always_comb begin
      for (int j = 0; j < MAX_DIGITS; j++) begin
         adj_a[j*4 +: 4] = (bcd_ff[j*4 +: 4] >= b2da_pkg::BCD_ADJUST_MIN)
                           ? bcd_ff[j*4 +: 4] + b2da_pkg::BCD_ADJUST_ADD
                           : bcd_ff[j*4 +: 4];
      end
      carry_a = adj_a[BCD_BITS-1];
      mid     = {adj_a[BCD_BITS-2:0], shift_ff[PAD_BITS-1]};
      for (int j = 0; j < MAX_DIGITS; j++) begin
         adj_b[j*4 +: 4] = (mid[j*4 +: 4] >= b2da_pkg::BCD_ADJUST_MIN)
                           ? mid[j*4 +: 4] + b2da_pkg::BCD_ADJUST_ADD
                           : mid[j*4 +: 4];
      end
      carry_b  = adj_b[BCD_BITS-1];
      bcd_step = {adj_b[BCD_BITS-2:0], shift_ff[PAD_BITS-2]};
   end

   always_comb begin
      top_digit = '0;
      for (int j = 0; j < MAX_DIGITS; j++) begin
         if (bcd_ff[j*4 +: 4] != 4'd0) begin
            top_digit = CNT_BITS'(j + 1);
         end
      end
      if (ovf_ff) begin
         count = CNT_BITS'(MAX_DIGITS);
      end else if (top_digit == '0) begin
         count = CNT_BITS'(1);
      end else begin
         count = top_digit;
      end
   end

   assign push_data = {framed_ff, count, bcd_ff};

   always_comb begin
      state_in   = state_ff;
      shift_in   = shift_ff;
      bcd_in     = bcd_ff;
      ovf_in     = ovf_ff;
      framed_in  = framed_ff;
      step_in    = step_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         b2da_pkg::FE_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               shift_in  = PAD_BITS'(scaled);
               bcd_in    = '0;
               ovf_in    = 1'b0;
               framed_in = label_mode;
               step_in   = STEP_BITS'(STEPS - 1);
               state_in  = b2da_pkg::FE_CONVERT;
            end
         end
         b2da_pkg::FE_CONVERT: begin
            shift_in = shift_ff << 2;
            bcd_in   = bcd_step;
            ovf_in   = ovf_ff | carry_a | carry_b;
            if (step_ff == '0) begin
               state_in = b2da_pkg::FE_PUSH;
            end else begin
               step_in = step_ff - STEP_BITS'(1);
            end
         end
         b2da_pkg::FE_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = b2da_pkg::FE_IDLE;
            end
         end
         default: begin
            state_in = b2da_pkg::FE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2da_pkg::FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff  <= shift_in;
      bcd_ff    <= bcd_in;
      ovf_ff    <= ovf_in;
      framed_ff <= framed_in;
      step_ff   <= step_in;
   end

endmodule

@@ rtl/core/b2da_queue.sv @@
`timescale 1ns / 1ps

module b2da_queue #(
   parameter int DATA_BITS = 45
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output logic [DATA_BITS-1:0] pop_data
);

   logic [DATA_BITS-1:0] entries_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/b2da_back.sv @@
`timescale 1ns / 1ps

module b2da_back #(
   parameter int MAX_DIGITS = 10,
   parameter int CNT_BITS   = 4,
   parameter int ENTRY_BITS = 45
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  logic [ENTRY_BITS-1:0] pop_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_char_code,
   output logic                  rsp_last,
   output logic [3:0]            rsp_digit_count
);

   localparam int BCD_BITS = MAX_DIGITS * 4;
   localparam int IDX_BITS = $clog2(MAX_DIGITS);

   b2da_pkg::back_state_type state_ff, state_in;

   logic [BCD_BITS-1:0] digits_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                framed_ff;
   logic [IDX_BITS-1:0] ptr_ff, ptr_in;
   logic                valid_ff, valid_in;
   logic [7:0]          char_ff, char_in;
   logic                last_ff, last_in;
   logic [3:0]          dcount_ff;

   logic                take, emit, slot_free;
   logic [3:0]          cur_digit;
   logic [CNT_BITS-1:0] in_count;

   assign slot_free = ~valid_ff | rsp_ready;
   assign take      = pop_valid & pop_ready;
   assign in_count  = pop_data[BCD_BITS +: CNT_BITS];
   assign cur_digit = digits_ff[{ptr_ff, 2'b00} +: 4];

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      pop_ready = 1'b0;
      emit      = 1'b0;
      char_in   = b2da_pkg::CHAR_ZERO + {4'd0, cur_digit};
      last_in   = 1'b0;
      unique case (state_ff)
         b2da_pkg::BE_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               ptr_in   = IDX_BITS'(in_count - CNT_BITS'(1));
               state_in = pop_data[ENTRY_BITS-1] ? b2da_pkg::BE_SPACE
                                                 : b2da_pkg::BE_DIGITS;
            end
         end
         b2da_pkg::BE_SPACE: begin
            char_in = b2da_pkg::CHAR_SPACE;
            if (slot_free) begin
               emit     = 1'b1;
               state_in = b2da_pkg::BE_OPEN;
            end
         end
         b2da_pkg::BE_OPEN: begin
            char_in = b2da_pkg::CHAR_OPEN;
            if (slot_free) begin
               emit     = 1'b1;
               state_in = b2da_pkg::BE_DIGITS;
            end
         end
         b2da_pkg::BE_DIGITS: begin
            // digits go out most significant first
            last_in = ~framed_ff & (ptr_ff == '0);
            if (slot_free) begin
               emit = 1'b1;
               if (ptr_ff == '0) begin
                  state_in = framed_ff ? b2da_pkg::BE_PERCENT : b2da_pkg::BE_IDLE;
               end else begin
                  ptr_in = ptr_ff - IDX_BITS'(1);
               end
            end
         end
         b2da_pkg::BE_PERCENT: begin
            char_in = b2da_pkg::CHAR_PERCENT;
            if (slot_free) begin
               emit     = 1'b1;
               state_in = b2da_pkg::BE_CLOSE;
            end
         end
         b2da_pkg::BE_CLOSE: begin
            char_in = b2da_pkg::CHAR_CLOSE;
            last_in = 1'b1;
            if (slot_free) begin
               emit     = 1'b1;
               state_in = b2da_pkg::BE_IDLE;
            end
         end
         default: begin
            state_in = b2da_pkg::BE_IDLE;
         end
      endcase
   end

   assign valid_in = emit | (valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2da_pkg::BE_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (take) begin
         digits_ff <= pop_data[BCD_BITS-1:0];
         count_ff  <= in_count;
         framed_ff <= pop_data[ENTRY_BITS-1];
      end
      if (emit) begin
         char_ff   <= char_in;
         last_ff   <= last_in;
         dcount_ff <= 4'(count_ff);
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_char_code   = char_ff;
   assign rsp_last        = last_ff;
   assign rsp_digit_count = dcount_ff;

endmodule

@@ rtl/core/binary_to_decimal_ascii_unit.sv @@
// the first character leaves once the request has been converted, pushed, queued, loaded by the back and registered
// a new request is taken only once the front has pushed the last one; the pace is set by the
//    front converter, which shifts two value bits per cycle through the bcd digits
// the back emits one character per cycle while the receiver is ready, and loads each queue entry in its idle state
// reset is synchronous and active high; it clears control state and label_mode only
`timescale 1ns / 1ps

module binary_to_decimal_ascii_unit #(
   parameter int MAX_DIGITS = 10,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_char_code,
   output logic                  rsp_last,
   output logic [3:0]            rsp_digit_count,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_BITS   = $clog2(MAX_DIGITS + 1);
   localparam int ENTRY_BITS = MAX_DIGITS * 4 + CNT_BITS + 1;

   logic label_mode_ff, label_mode_in;
   logic csr_hit;

   logic                  push_valid, push_ready;
   logic [ENTRY_BITS-1:0] push_data;
   logic                  pop_valid, pop_ready;
   logic [ENTRY_BITS-1:0] pop_data;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == b2da_pkg::CSR_LABEL_MODE);
   assign csr_prdata = csr_hit ? {31'd0, label_mode_ff} : 32'd0;

   always_comb begin
      label_mode_in = label_mode_ff;
      if (csr_psel & csr_penable & csr_pwrite & csr_pready & csr_hit) begin
         label_mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_mode_ff <= 1'b0;
      end else begin
         label_mode_ff <= label_mode_in;
      end
   end

   b2da_front #(
      .MAX_DIGITS (MAX_DIGITS),
      .VALUE_BITS (VALUE_BITS),
      .CNT_BITS   (CNT_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .label_mode (label_mode_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   b2da_queue #(
      .DATA_BITS (ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   b2da_back #(
      .MAX_DIGITS (MAX_DIGITS),
      .CNT_BITS   (CNT_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_code   (rsp_char_code),
      .rsp_last        (rsp_last),
      .rsp_digit_count (rsp_digit_count)
   );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_DIGITS    = 10;
   localparam int VALUE_BITS    = 32;
   localparam int SETTLE_CYCLES = 48;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int REPORT_LIMIT  = 40;

   // byte addresses: word index sits on address bit 2
   localparam logic [2:0] LABEL_MODE_ADDR = {b2da_pkg::CSR_LABEL_MODE, 2'b00};
   localparam logic [2:0] UNMAPPED_ADDR   = {~b2da_pkg::CSR_LABEL_MODE, 2'b00};

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
      logic [3:0] digit_count;
   } text_char_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_char_code;
   logic                  rsp_last;
   logic [3:0]            rsp_digit_count;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [2:0]            csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   text_char_type pending_chars[$];
   logic          label_mode_shadow = 1'b0;
   int            sender_idle_pct = 16;
   int            receiver_stall_pct = 79;
   int            error_count = 0;
   int            values_sent = 0;
   int            labeled_values = 0;
   int            chars_checked = 0;
   int            cycle_count = 0;

   binary_to_decimal_ascii_unit #(
      .MAX_DIGITS(MAX_DIGITS),
      .VALUE_BITS(VALUE_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_char_code(rsp_char_code),
      .rsp_last(rsp_last),
      .rsp_digit_count(rsp_digit_count),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run did not finish, %0d characters still pending", $time,
                  pending_chars.size());
         $display("tb: failure");
         $finish;
      end
   end

   // decimal text for one request, scaled by five and framed when label mode is on
   function automatic void predict_string(input logic [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] scaled;
      logic [3:0]            digits [MAX_DIGITS];
      int                    count;
      logic [3:0]            count_field;
      logic                  framed;
      framed = label_mode_shadow;
      scaled = framed ? value * 32'd5 : value;
      count = 0;
      do begin
         digits[count] = 4'(scaled % 10);
         scaled = scaled / 10;
         count++;
      end while (scaled != 0 && count < MAX_DIGITS);
      count_field = count[3:0];
      if (framed) begin
         pending_chars.push_back('{b2da_pkg::CHAR_SPACE, 1'b0, count_field});
         pending_chars.push_back('{b2da_pkg::CHAR_OPEN, 1'b0, count_field});
      end
      for (int k = count - 1; k >= 0; k--) begin
         pending_chars.push_back('{b2da_pkg::CHAR_ZERO + 8'(digits[k]),
                                   !framed && k == 0, count_field});
      end
      if (framed) begin
         pending_chars.push_back('{b2da_pkg::CHAR_PERCENT, 1'b0, count_field});
         pending_chars.push_back('{b2da_pkg::CHAR_CLOSE, 1'b1, count_field});
      end
   endfunction

   task automatic report_mismatch(input string field, input int want, input int got);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // output side: random backpressure and in-order character check
   always @(posedge clock) begin : char_check
      text_char_type want;
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("%0t: unexpected character, expected none, got %0d", $time,
                        rsp_char_code);
            end
         end else begin
            want = pending_chars.pop_front();
            chars_checked++;
            if (rsp_char_code !== want.char_code) begin
               report_mismatch("char_code", want.char_code, rsp_char_code);
            end
            if (rsp_last !== want.last) begin
               report_mismatch("last", want.last, rsp_last);
            end
            if (rsp_digit_count !== want.digit_count) begin
               report_mismatch("digit_count", want.digit_count, rsp_digit_count);
            end
         end
      end
   end

   // valid is left high after acceptance so back-to-back requests need one assignment
   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      if (label_mode_shadow) labeled_values++;
      predict_string(value);
      values_sent++;
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drain();
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr[2] == b2da_pkg::CSR_LABEL_MODE) label_mode_shadow = data[0];
      @(posedge clock);
   endtask

   task automatic csr_check_label_mode();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= LABEL_MODE_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {31'b0, label_mode_shadow}) begin
         report_mismatch("label_mode readback", label_mode_shadow, csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [VALUE_BITS-1:0] power_of_ten(input int exponent);
      logic [VALUE_BITS-1:0] p;
      p = 1;
      repeat (exponent) p = p * 10;
      return p;
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      int unsigned kind;
      kind = $urandom_range(9);
      case (kind)
         0, 1, 2, 3: return $urandom();
         4: return $urandom_range(0, 9);
         5: return $urandom_range(0, 99999);
         6: return power_of_ten($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
         // around the point where five times the value wraps
         7: return 32'd858993459 + $urandom_range(0, 4) - 2;
         8: return $urandom() | 32'hF000_0000;
         default: return $urandom() >> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic test_register_access();
      csr_check_label_mode();
      csr_write(LABEL_MODE_ADDR, 32'h0000_0001);
      csr_check_label_mode();
      // unmapped index must leave label mode alone
      csr_write(UNMAPPED_ADDR, 32'h0000_0000);
      csr_check_label_mode();
      // only bit 0 counts
      csr_write(LABEL_MODE_ADDR, 32'hFFFF_FFFE);
      csr_check_label_mode();
   endtask

   task automatic test_plain_extremes();
      logic [VALUE_BITS-1:0] values [13];
      values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999999999,
                 32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
                 32'h5555_5555, 32'hAAAA_AAAA};
      csr_write(LABEL_MODE_ADDR, 32'h0000_0000);
      foreach (values[k]) send_value(values[k]);
      end_burst();
      wait_drain();
   endtask

   task automatic test_label_framing();
      logic [VALUE_BITS-1:0] values [9];
      values = '{32'd0, 32'd1, 32'd2, 32'd200000000, 32'd858993459, 32'd858993460,
                 32'hFFFF_FFFF, 32'd1717986919, 32'h3333_3334};
      csr_write(LABEL_MODE_ADDR, 32'hFFFF_FFFF);
      csr_check_label_mode();
      foreach (values[k]) send_value(values[k]);
      end_burst();
      wait_drain();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 16; receiver_stall_pct = 79; end
            1: begin sender_idle_pct = 79; receiver_stall_pct = 16; end
            default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
         endcase
         for (int batch = 0; batch < 2; batch++) begin
            csr_write(LABEL_MODE_ADDR, {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0,
                                        1'((phase + batch) % 2)});
            for (int k = 0; k < 43; k++) begin
               // hold off mid-batch until the output side is empty
               if (k == 21) begin
                  end_burst();
                  while (pending_chars.size() != 0) @(posedge clock);
               end
               send_value(pick_value());
            end
            end_burst();
            wait_drain();
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_plain_extremes();
      test_label_framing();
      test_random_traffic();
      wait_drain();
      $display("tb: converted %0d values (%0d framed), checked %0d characters",
               values_sent, labeled_values, chars_checked);
      $display("tb: idle mixes covered sender-heavy, receiver-heavy and none");
      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/b2da_pkg.sv
rtl/core/b2da_front.sv
rtl/core/b2da_queue.sv
rtl/core/b2da_back.sv
rtl/core/binary_to_decimal_ascii_unit.sv
verif/testbench.sv
